### hdl/pwi_pkg.sv
package pwi_pkg;

	// Command codes carried by an input beat.
	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_QUERY  = 2'd2
	} cmd_t;

	// Status codes returned with every result beat.
	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_RANGE = 2'd1,
		STS_FULL  = 2'd2
	} status_t;

	// One stored table point: unsigned Q12.4 wavelength and signed Q16.16 value.
	typedef struct packed {
		logic [15:0]        wl;
		logic signed [31:0] val;
	} point_t;

	// Arithmetic widths of the interpolation datapath.
	localparam int WL_W   = 16;
	localparam int VAL_W  = 32;
	localparam int DY_W   = VAL_W + 1;
	localparam int DL_W   = WL_W + 1;
	localparam int PROD_W = DY_W + DL_W;
	localparam int MAG_W  = PROD_W - 1;
	localparam int SUM_W  = PROD_W + 1;
	localparam int DCNT_W = $clog2(MAG_W);

endpackage

### hdl/pwi_cell.sv
module pwi_cell (
	input  logic            clk,
	input  logic            shift,
	input  logic            load,
	input  pwi_pkg::point_t ld_pt,
	input  pwi_pkg::point_t nxt_pt,
	output pwi_pkg::point_t pt
);

	pwi_pkg::point_t pt_q;

	// A cell either takes a newly appended point or the point of its neighbor.
	always_ff @(posedge clk) begin
		if (load) begin
			pt_q <= ld_pt;
		end else if (shift) begin
			pt_q <= nxt_pt;
		end
	end

	assign pt = pt_q;

endmodule

### hdl/pwi_div.sv
module pwi_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [pwi_pkg::MAG_W-1:0]   dvd,
	input  logic [pwi_pkg::WL_W-1:0]    dvs,
	output logic                        done,
	output logic [pwi_pkg::MAG_W-1:0]   quo
);

	logic [pwi_pkg::MAG_W-1:0]  quo_q;
	logic [pwi_pkg::WL_W-1:0]   rem_q;
	logic [pwi_pkg::WL_W-1:0]   dvs_q;
	logic [pwi_pkg::DCNT_W-1:0] cnt_q;
	logic                       run_q;
	logic                       done_q;
	logic [pwi_pkg::WL_W:0]     trial;
	logic [pwi_pkg::WL_W-1:0]   diff;
	logic                       ge;

	// One restoring step: bring down the next dividend bit and try a subtract.
	// The remainder stays below the divisor, so the difference fits the divisor width.
	assign trial = {rem_q, quo_q[pwi_pkg::MAG_W-1]};
	assign diff  = trial[pwi_pkg::WL_W-1:0] - dvs_q;
	assign ge    = trial >= {1'b0, dvs_q};

	// Control of the iteration count and the finish pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !go && run_q && cnt_q == '0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= pwi_pkg::DCNT_W'(pwi_pkg::MAG_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// The dividend register shifts out its top bit and fills with quotient bits.
	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dvd;
			rem_q <= '0;
			dvs_q <= dvs;
		end else if (run_q) begin
			quo_q <= {quo_q[pwi_pkg::MAG_W-2:0], ge};
			rem_q <= ge ? diff : trial[pwi_pkg::WL_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

### hdl/piecewise_linear_interpolator.sv
// Channel | Direction | Signals                                    | Handshake
// input   | in        | command, wavelength, point_value           | start high, busy low
// result  | out       | result_value, status                       | done, one cycle
//
// Clear, append and the unused command answer in the cycle after acceptance; busy stays low.
// A query on a nonempty table rotates the cell chain once; a miss answers at the end of the scan,
// an exact match after the scan and the S_MUL state, and an interpolation after the scan and then
// multiply, divider load, 49 divider steps, the S_DIV exit and the S_FIN sum.
// Reset clears the point count and all control state; stored points are not cleared.
// The receiver cannot stall: a result beat is valid for exactly one cycle.
module piecewise_linear_interpolator #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic [15:0]        wavelength,
	input  logic signed [31:0] point_value,
	output logic               done,
	output logic signed [31:0] result_value,
	output logic [1:0]         status
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = $clog2(TABLE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MUL,
		S_DGO,
		S_DIV,
		S_FIN
	} state_t;

	state_t                          state_q;
	logic [CW-1:0]                   count_q;
	logic [SW-1:0]                   step_q;
	logic [15:0]                     q_q;
	logic                            found_q;
	logic                            brk_q;
	logic signed [31:0]              hold_val_q;
	logic signed [pwi_pkg::DY_W-1:0] dy_q;
	logic signed [pwi_pkg::DL_W-1:0] dl_q;
	logic signed [pwi_pkg::DL_W-1:0] dx_q;
	logic signed [pwi_pkg::PROD_W-1:0] prod_q;
	logic                            done_q;
	logic signed [31:0]              res_q;
	pwi_pkg::status_t                sts_q;

	pwi_pkg::point_t                 cell_pt [TABLE_DEPTH];
	pwi_pkg::point_t                 ld_pt;
	pwi_pkg::point_t                 p0;
	pwi_pkg::point_t                 p1;
	logic                            accept;
	logic                            do_append;
	logic                            shift_en;
	logic [CW-1:0]                   step_x;
	logic                            in_tab;
	logic                            nxt_in;
	logic                            exact;
	logic                            bracket;
	logic                            hit;
	logic                            last;
	logic                            fin;

	logic                            div_go;
	logic                            div_done;
	logic [pwi_pkg::MAG_W-1:0]       div_dvd;
	logic [pwi_pkg::WL_W-1:0]        div_dvs;
	logic [pwi_pkg::MAG_W-1:0]       div_quo;
	logic [pwi_pkg::MAG_W-1:0]       prod_abs;
	logic [pwi_pkg::WL_W-1:0]        dx_abs;
	logic                            q_neg;
	logic signed [pwi_pkg::PROD_W-1:0] t_val;
	logic signed [pwi_pkg::SUM_W-1:0]  sum;
	logic signed [31:0]              sat_val;

	assign busy      = state_q != S_IDLE;
	assign accept    = start && !busy;
	assign do_append = accept && command == pwi_pkg::CMD_APPEND;
	assign shift_en  = state_q == S_SCAN;
	assign ld_pt     = '{wl: wavelength, val: point_value};

	// Chain of point cells; during a query the chain rotates toward cell zero once.
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		pwi_cell u_cell (
			.clk    (clk),
			.shift  (shift_en),
			.load   (do_append && count_q == CW'(i)),
			.ld_pt  (ld_pt),
			.nxt_pt (cell_pt[(i + 1) % TABLE_DEPTH]),
			.pt     (cell_pt[i])
		);
	end

	// Scan tests on the two points at the head of the chain.
	assign p0      = cell_pt[0];
	assign p1      = cell_pt[1];
	assign step_x  = CW'(step_q);
	assign in_tab  = step_x < count_q;
	assign nxt_in  = (step_x + CW'(1)) < count_q;
	assign exact   = in_tab && q_q == p0.wl;
	assign bracket = nxt_in && ((q_q > p0.wl && q_q < p1.wl) || (q_q < p0.wl && q_q > p1.wl));
	assign hit     = !found_q && (exact || bracket);
	assign last    = step_q == SW'(TABLE_DEPTH - 1);

	// Every item ends with one result beat: table commands, the unused command and empty-table
	// queries at once, other queries at the end of the scan, the exact lookup or the division.
	assign fin = (accept && !(command == pwi_pkg::CMD_QUERY && count_q != '0))
		|| (state_q == S_SCAN && last && !found_q && !hit)
		|| (state_q == S_MUL && !brk_q)
		|| state_q == S_FIN;

	// Magnitudes and sign for the truncating division.
	assign prod_abs = prod_q[pwi_pkg::PROD_W-1] ? pwi_pkg::MAG_W'(-prod_q)
		: pwi_pkg::MAG_W'(prod_q);
	assign dx_abs   = dx_q[pwi_pkg::DL_W-1] ? pwi_pkg::WL_W'(-dx_q) : pwi_pkg::WL_W'(dx_q);
	assign q_neg    = prod_q[pwi_pkg::PROD_W-1] ^ dx_q[pwi_pkg::DL_W-1];
	assign div_go   = state_q == S_DGO;
	assign div_dvd  = prod_abs;
	assign div_dvs  = dx_abs;

	pwi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.dvd    (div_dvd),
		.dvs    (div_dvs),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Final sum from the second point of the pair, clamped to 32 bits.
	assign t_val = q_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
	assign sum   = pwi_pkg::SUM_W'(hold_val_q) + pwi_pkg::SUM_W'(t_val);
	always_comb begin
		if (sum > pwi_pkg::SUM_W'(32'sh7FFF_FFFF)) begin
			sat_val = 32'sh7FFF_FFFF;
		end else if (sum < -pwi_pkg::SUM_W'(33'sh0_8000_0000)) begin
			sat_val = 32'sh8000_0000;
		end else begin
			sat_val = sum[31:0];
		end
	end

	// Sequencer with the registered result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			step_q     <= '0;
			q_q        <= '0;
			found_q    <= 1'b0;
			brk_q      <= 1'b0;
			hold_val_q <= '0;
			dy_q       <= '0;
			dl_q       <= '0;
			dx_q       <= '0;
			prod_q     <= '0;
			done_q     <= 1'b0;
			res_q      <= '0;
			sts_q      <= pwi_pkg::STS_OK;
		end else begin
			done_q <= fin;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (command)
							pwi_pkg::CMD_CLEAR: begin
								count_q <= '0;
								res_q   <= '0;
								sts_q   <= pwi_pkg::STS_OK;
							end
							pwi_pkg::CMD_APPEND: begin
								res_q <= '0;
								if (count_q == CW'(TABLE_DEPTH)) begin
									sts_q <= pwi_pkg::STS_FULL;
								end else begin
									count_q <= count_q + 1'b1;
									sts_q   <= pwi_pkg::STS_OK;
								end
							end
							pwi_pkg::CMD_QUERY: begin
								if (count_q == '0) begin
									res_q <= '0;
									sts_q <= pwi_pkg::STS_RANGE;
								end else begin
									q_q     <= wavelength;
									step_q  <= '0;
									found_q <= 1'b0;
									brk_q   <= 1'b0;
									state_q <= S_SCAN;
								end
							end
							default: begin
								res_q <= '0;
								sts_q <= pwi_pkg::STS_OK;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (hit) begin
						found_q    <= 1'b1;
						brk_q      <= !exact;
						hold_val_q <= exact ? p0.val : p1.val;
						dy_q       <= pwi_pkg::DY_W'(p1.val) - pwi_pkg::DY_W'(p0.val);
						dl_q       <= $signed({1'b0, q_q}) - $signed({1'b0, p1.wl});
						dx_q       <= $signed({1'b0, p1.wl}) - $signed({1'b0, p0.wl});
					end
					step_q <= step_q + 1'b1;
					if (last) begin
						if (found_q || hit) begin
							state_q <= S_MUL;
						end else begin
							res_q   <= '0;
							sts_q   <= pwi_pkg::STS_RANGE;
							state_q <= S_IDLE;
						end
					end
				end
				S_MUL: begin
					if (brk_q) begin
						prod_q  <= pwi_pkg::PROD_W'(dy_q) * pwi_pkg::PROD_W'(dl_q);
						state_q <= S_DGO;
					end else begin
						res_q   <= hold_val_q;
						sts_q   <= pwi_pkg::STS_OK;
						state_q <= S_IDLE;
					end
				end
				S_DGO: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					res_q   <= sat_val;
					sts_q   <= pwi_pkg::STS_OK;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign result_value = res_q;
	assign status       = sts_q;

endmodule

### hdl/pwi_checker.sv
module pwi_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [1:0]         command,
	input logic               done,
	input logic signed [31:0] result_value,
	input logic [1:0]         status
);

	// Table maintenance commands answer in the very next cycle.
	a_quick_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command != pwi_pkg::CMD_QUERY |=> done && !busy)
		else $error("non-query command did not answer in the next cycle");

	// An accepted query either starts working or answers at once.
	a_query_go: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == pwi_pkg::CMD_QUERY |=> busy || done)
		else $error("accepted query neither ran nor answered");

	// A result beat is never shown while a query is still in flight.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// The end of a query always comes with its result beat.
	a_end_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("query finished without a result beat");

	// A failed or refused beat carries a zero value.
	a_zero_fail: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != pwi_pkg::STS_OK |-> result_value == 32'sd0)
		else $error("nonzero value on a failed result beat");

endmodule

bind piecewise_linear_interpolator pwi_checker u_pwi_checker (.*);

### bench/piecewise_linear_interpolator_tb.sv
`timescale 1ns / 100ps

module piecewise_linear_interpolator_tb;

	localparam int TABLE_DEPTH = 256;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int WL_SPACING = 65536 / TABLE_DEPTH;
	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

	// One expected result beat.
	typedef struct {
		logic signed [31:0] value;
		pwi_pkg::status_t   st;
	} answer_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [1:0]         command = pwi_pkg::CMD_CLEAR;
	logic [15:0]        wavelength = '0;
	logic signed [31:0] point_value = '0;
	logic               busy;
	logic               done;
	logic signed [31:0] result_value;
	logic [1:0]         status;

	// Shadow copy of the point table.
	logic [15:0]        table_wl [TABLE_DEPTH];
	logic signed [31:0] table_val [TABLE_DEPTH];
	int                 point_count = 0;

	answer_t pending_answers [$];
	int      mismatch_count = 0;
	int      cycle_count = 0;
	int      beats_sent = 0;
	int      idle_pct = 0;

	always #6 clk = ~clk;

	piecewise_linear_interpolator #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.wavelength(wavelength),
		.point_value(point_value),
		.done(done),
		.result_value(result_value),
		.status(status)
	);

	// Scan the table for an exact match or the first bracketing pair.
	function automatic bit interpolate_at(input logic [15:0] q, output logic signed [31:0] val);
		longint qi, w0, w1, v0, v1, t, s;
		qi = q;
		val = '0;
		for (int i = 0; i < point_count; i++) begin
			w0 = table_wl[i];
			if (qi == w0) begin
				val = table_val[i];
				return 1'b1;
			end
			if (i + 1 < point_count) begin
				w1 = table_wl[i + 1];
				if ((qi > w0 && qi < w1) || (qi < w0 && qi > w1)) begin
					v0 = table_val[i];
					v1 = table_val[i + 1];
					// Integer division truncates toward zero, as the block does.
					t = ((v1 - v0) * (qi - w1)) / (w1 - w0);
					s = v1 + t;
					if (s > VAL_MAX)
						s = VAL_MAX;
					else if (s < VAL_MIN)
						s = VAL_MIN;
					val = s[31:0];
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	// Apply one command to the shadow table and return the answer it should give.
	function automatic answer_t table_step(input logic [1:0] cmd, input logic [15:0] wl,
			input logic signed [31:0] pv);
		answer_t ans;
		ans.value = '0;
		ans.st = pwi_pkg::STS_OK;
		case (cmd)
			pwi_pkg::CMD_CLEAR: begin
				point_count = 0;
			end
			pwi_pkg::CMD_APPEND: begin
				if (point_count < TABLE_DEPTH) begin
					table_wl[point_count] = wl;
					table_val[point_count] = pv;
					point_count++;
				end else begin
					ans.st = pwi_pkg::STS_FULL;
				end
			end
			pwi_pkg::CMD_QUERY: begin
				if (!interpolate_at(wl, ans.value)) begin
					ans.value = '0;
					ans.st = pwi_pkg::STS_RANGE;
				end
			end
			default: begin
			end
		endcase
		return ans;
	endfunction

	// Send one command beat, with an optional idle gap ahead of it.
	task automatic send_beat(input logic [1:0] cmd, input logic [15:0] wl,
			input logic signed [31:0] pv);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		wavelength <= wl;
		point_value <= pv;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_answers.insert(pending_answers.size(), table_step(cmd, wl, pv));
		beats_sent++;
	endtask

	// Stop sending until every outstanding answer has come back.
	task automatic hold_until_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	// Empty table, unused command, extremes, both pair orders, duplicates, table ends.
	task automatic test_directed();
		idle_pct = 0;
		send_beat(pwi_pkg::CMD_QUERY, 16'd100, 32'sd0);
		send_beat(CMD_NOP, 16'hFFFF, 32'shFFFF_FFFF);
		send_beat(pwi_pkg::CMD_APPEND, 16'h0000, VAL_MIN);
		send_beat(pwi_pkg::CMD_APPEND, 16'hFFFF, VAL_MAX);
		send_beat(pwi_pkg::CMD_QUERY, 16'h0000, 32'sd0);
		send_beat(pwi_pkg::CMD_QUERY, 16'hFFFF, 32'sd0);
		send_beat(pwi_pkg::CMD_QUERY, 16'h8000, 32'sd0);
		send_beat(pwi_pkg::CMD_CLEAR, 16'hFFFF, VAL_MAX);
		send_beat(pwi_pkg::CMD_QUERY, 16'd5, 32'sd0);
		send_beat(pwi_pkg::CMD_APPEND, 16'd800, 32'sh0001_0000);
		send_beat(pwi_pkg::CMD_APPEND, 16'd400, -32'sh0003_0000);
		send_beat(pwi_pkg::CMD_APPEND, 16'd400, 32'sd7);
		send_beat(pwi_pkg::CMD_APPEND, 16'd1200, VAL_MAX);
		send_beat(pwi_pkg::CMD_APPEND, 16'd1600, VAL_MIN);
		send_beat(pwi_pkg::CMD_QUERY, 16'd600, 32'sd0);
		send_beat(pwi_pkg::CMD_QUERY, 16'd400, 32'sd0);
		send_beat(pwi_pkg::CMD_QUERY, 16'd1000, 32'sd0);
		send_beat(pwi_pkg::CMD_QUERY, 16'd1401, 32'sd0);
		send_beat(pwi_pkg::CMD_QUERY, 16'd1600, 32'sd0);
		send_beat(pwi_pkg::CMD_QUERY, 16'd1700, 32'sd0);
		send_beat(pwi_pkg::CMD_QUERY, 16'd100, 32'sd0);
		send_beat(CMD_NOP, 16'h0000, 32'sd0);
	endtask

	// Fill the table to the brim, try to overfill it, then query across it.
	task automatic test_full_table();
		int idx;
		idle_pct = 0;
		send_beat(pwi_pkg::CMD_CLEAR, 16'h0000, 32'sd0);
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_beat(pwi_pkg::CMD_APPEND,
				16'(i * WL_SPACING + $urandom_range(WL_SPACING - 1)), $urandom);
		send_beat(pwi_pkg::CMD_APPEND, 16'hFFFF, VAL_MAX);
		send_beat(pwi_pkg::CMD_APPEND, 16'h0000, VAL_MIN);
		hold_until_drained();
		idle_pct = 26;
		send_beat(pwi_pkg::CMD_QUERY, table_wl[TABLE_DEPTH - 1], 32'sd0);
		send_beat(pwi_pkg::CMD_QUERY, table_wl[0], 32'sd0);
		send_beat(pwi_pkg::CMD_QUERY, 16'hFFFF, 32'sd0);
		send_beat(pwi_pkg::CMD_QUERY, 16'h0000, 32'sd0);
		for (int k = 0; k < 4; k++) begin
			idx = $urandom_range(TABLE_DEPTH - 2);
			send_beat(pwi_pkg::CMD_QUERY,
				16'($urandom_range(table_wl[idx], table_wl[idx + 1])), $urandom);
		end
	endtask

	// Mostly clear, append, query sequences with random content; some noise beats.
	task automatic test_random(input int pct, input int beats);
		int          stop_at;
		int          n;
		int          shape;
		int          step;
		int          idx;
		logic [15:0] wl;
		logic [15:0] lo;
		logic [15:0] hi;
		idle_pct = pct;
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at) begin
			if ($urandom_range(9) == 0) begin
				send_beat(2'($urandom_range(3)), 16'($urandom), $urandom);
			end else begin
				send_beat(pwi_pkg::CMD_CLEAR, 16'($urandom), $urandom);
				n = $urandom_range(1, 12);
				shape = $urandom_range(2);
				step = 65535 / (n + 1);
				wl = (shape == 1) ? 16'hFFFF : 16'h0000;
				for (int k = 0; k < n; k++) begin
					// Rising, falling or scattered wavelengths, the last with repeats.
					case (shape)
						0: wl = wl + 16'($urandom_range(1, step));
						1: wl = wl - 16'($urandom_range(1, step));
						default: begin
							if (k == 0 || $urandom_range(3) != 0)
								wl = 16'($urandom);
						end
					endcase
					send_beat(pwi_pkg::CMD_APPEND, wl, $urandom);
				end
				for (int k = $urandom_range(2, 6); k > 0; k--) begin
					case ($urandom_range(3))
						0: wl = table_wl[$urandom_range(point_count - 1)];
						3: wl = 16'($urandom);
						default: begin
							if (point_count < 2) begin
								wl = table_wl[0];
							end else begin
								idx = $urandom_range(point_count - 2);
								lo = table_wl[idx] < table_wl[idx + 1] ? table_wl[idx] : table_wl[idx + 1];
								hi = table_wl[idx] < table_wl[idx + 1] ? table_wl[idx + 1] : table_wl[idx];
								wl = (hi - lo >= 2) ? 16'($urandom_range(lo + 1, hi - 1)) : lo;
							end
						end
					endcase
					send_beat(pwi_pkg::CMD_QUERY, wl, $urandom);
				end
			end
		end
	endtask

	// Check each result beat against the oldest expected answer.
	always @(posedge clk) begin
		answer_t want;
		if (done) begin
			if (pending_answers.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result beat: value %0d status %0d", result_value, status);
			end else begin
				want = pending_answers.pop_front();
				if (result_value !== want.value || status !== want.st) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: value exp %0d got %0d, status exp %0d got %0d",
							want.value, result_value, want.st, status);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("piecewise_linear_interpolator_tb: errors");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_table();
		test_random(0, 35);
		test_random(67, 35);
		test_random(0, 35);
		test_random(26, 35);
		hold_until_drained();
		repeat (TABLE_DEPTH + 60) @(posedge clk);
		if (mismatch_count == 0)
			$display("piecewise_linear_interpolator_tb: clean");
		else
			$display("piecewise_linear_interpolator_tb: errors");
		$finish;
	end

endmodule
